### rtl/txrb_pkg.sv
// Shared constants, operation codes and result type for the transmit ring buffer.
package txrb_pkg;

  // Ring size and the widths that follow from it.
  localparam int BUF_DEPTH = 256;
  localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Fixed field widths of the words on the channels.
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_DONE  = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // One result word.
  typedef struct packed {
    logic               status;
    logic               transfer_started;
    logic [INDEX_W-1:0] transfer_start;
    logic [LEN_W-1:0]   transfer_length;
    logic               idle;
    logic [LEN_W-1:0]   fill_count;
    logic [BYTE_W-1:0]  read_data;
  } result_t;

endpackage

### rtl/txrb_if.sv
// Valid/ready channel interfaces for the operation words and the result words.
interface txrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [txrb_pkg::OP_W-1:0]      operation;
  logic [txrb_pkg::BYTE_W-1:0]    data_byte;
  logic [txrb_pkg::INDEX_W-1:0]   fetch_index;

  modport source (output valid, operation, data_byte, fetch_index, input ready);
  modport sink   (input valid, operation, data_byte, fetch_index, output ready);
endinterface

interface txrb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic                           transfer_started;
  logic [txrb_pkg::INDEX_W-1:0]   transfer_start;
  logic [txrb_pkg::LEN_W-1:0]     transfer_length;
  logic                           idle;
  logic [txrb_pkg::LEN_W-1:0]     fill_count;
  logic [txrb_pkg::BYTE_W-1:0]    read_data;

  modport source (output valid, status, transfer_started, transfer_start, transfer_length,
                  idle, fill_count, read_data, input ready);
  modport sink   (input valid, status, transfer_started, transfer_start, transfer_length,
                  idle, fill_count, read_data, output ready);
endinterface

### rtl/txrb_store.sv
// Byte ring storage: one write port and one read port with registered read data.
module txrb_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [txrb_pkg::PTR_W-1:0]   wr_addr,
  input  logic [txrb_pkg::BYTE_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [txrb_pkg::PTR_W-1:0]   rd_addr,
  output logic [txrb_pkg::BYTE_W-1:0]  rd_data
);
  import txrb_pkg::*;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tx_ring_buffer_dma_chunker.sv
// Top level of the transmit ring buffer that hands out DMA chunk descriptors.
//
// The block takes one operation word per cycle, unless the output stalls, and
// returns one result word for each. Pointers, fill level and transfer size live
// in registers and are updated in the cycle a word is accepted; the byte ring is
// a 256-entry single-write, single-read memory. The ring read data is registered,
// so a result passes the memory read register and then the output register
// before it leaves. With the output taken every cycle the block sustains one word
// per cycle. A chunk never crosses the end of the ring, and stop empties the ring.
// Bytes read from entries never written are undefined.
module tx_ring_buffer_dma_chunker (
  input logic   clk,
  input logic   rst_n,
  txrb_in_if.sink    in_ch,
  txrb_out_if.source out_ch
);
  import txrb_pkg::*;

  // Control registers.
  logic [PTR_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] tsize_r, tsize_nxt;
  logic             idle_r, idle_nxt;

  // Pipeline registers.
  logic             p_valid_r;
  result_t          p_res_r, p_res_nxt;
  logic             p_rd_r;
  logic             out_valid_r;
  result_t          out_res_r, out_res_nxt;

  logic             in_acc;
  logic             p_adv;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] fetch_addr;
  logic             fetch_ok;
  logic [BYTE_W-1:0] mem_rdata;

  // Launch and retire arithmetic.
  logic [CNT_W-1:0] room_cur;
  logic [CNT_W-1:0] room_done;
  logic [CNT_W-1:0] fill_done;
  logic [PTR_W-1:0] rd_sum;
  logic [PTR_W-1:0] rd_done;

  assign p_adv       = p_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !p_valid_r || p_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign fetch_addr = PTR_W'(in_ch.fetch_index);
  assign fetch_ok   = 32'(in_ch.fetch_index) < 32'(BUF_DEPTH);

  // Room before the end of the ring, now and after a chunk retires.
  assign room_cur  = CNT_W'(BUF_DEPTH) - CNT_W'(rd_pos_r);
  assign fill_done = (tsize_r <= fill_r) ? (fill_r - tsize_r) : '0;
  assign rd_sum    = rd_pos_r + tsize_r[PTR_W-1:0];
  assign rd_done   = (tsize_r >= room_cur) ? '0 : rd_sum;
  assign room_done = CNT_W'(BUF_DEPTH) - CNT_W'(rd_done);

  assign mem_we = in_acc && (in_ch.operation == OP_PUT) && (fill_r < CNT_W'(BUF_DEPTH));
  assign mem_re = in_acc && (in_ch.operation == OP_READ) && fetch_ok;

  // Next state and result for the accepted word.
  always_comb begin
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;
    fill_nxt   = fill_r;
    tsize_nxt  = tsize_r;
    idle_nxt   = idle_r;
    p_res_nxt  = '0;
    case (in_ch.operation)
      OP_PUT: begin
        if (fill_r >= CNT_W'(BUF_DEPTH)) begin
          p_res_nxt.status = 1'b1;
        end else begin
          wr_pos_nxt = (32'(wr_pos_r) == BUF_DEPTH - 1) ? '0 : wr_pos_r + 1'b1;
          fill_nxt   = fill_r + 1'b1;
        end
      end
      OP_START: begin
        if (idle_r) begin
          tsize_nxt = (fill_r < room_cur) ? fill_r : room_cur;
          if (tsize_nxt != '0) begin
            idle_nxt                   = 1'b0;
            p_res_nxt.transfer_started = 1'b1;
            p_res_nxt.transfer_start   = INDEX_W'(rd_pos_r);
            p_res_nxt.transfer_length  = LEN_W'(tsize_nxt);
          end
        end
      end
      OP_DONE: begin
        if (!idle_r) begin
          fill_nxt   = fill_done;
          rd_pos_nxt = rd_done;
          if (fill_done == '0) begin
            idle_nxt = 1'b1;
          end else begin
            // Launch the next chunk at once; room is never zero.
            tsize_nxt                  = (fill_done < room_done) ? fill_done : room_done;
            p_res_nxt.transfer_started = 1'b1;
            p_res_nxt.transfer_start   = INDEX_W'(rd_done);
            p_res_nxt.transfer_length  = LEN_W'(tsize_nxt);
          end
        end
      end
      OP_STOP: begin
        idle_nxt   = 1'b1;
        rd_pos_nxt = '0;
        wr_pos_nxt = '0;
        fill_nxt   = '0;
        tsize_nxt  = '0;
      end
      default: begin
      end
    endcase
    p_res_nxt.idle       = idle_nxt;
    p_res_nxt.fill_count = LEN_W'(fill_nxt);
  end

  // Control state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      rd_pos_r <= '0;
      fill_r   <= '0;
      tsize_r  <= '0;
      idle_r   <= 1'b1;
    end else if (in_acc) begin
      wr_pos_r <= wr_pos_nxt;
      rd_pos_r <= rd_pos_nxt;
      fill_r   <= fill_nxt;
      tsize_r  <= tsize_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // Byte ring.
  txrb_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_pos_r),
    .wr_data (in_ch.data_byte),
    .rd_en   (mem_re),
    .rd_addr (fetch_addr),
    .rd_data (mem_rdata)
  );

  // Stage that waits for the ring read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_acc) begin
      p_valid_r <= 1'b1;
    end else if (p_adv) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_res_r <= p_res_nxt;
      p_rd_r  <= mem_re;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Merge the ring read data into the waiting result.
  always_comb begin
    out_res_nxt           = p_res_r;
    out_res_nxt.read_data = p_rd_r ? mem_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_res_r.status;
  assign out_ch.transfer_started = out_res_r.transfer_started;
  assign out_ch.transfer_start   = out_res_r.transfer_start;
  assign out_ch.transfer_length  = out_res_r.transfer_length;
  assign out_ch.idle             = out_res_r.idle;
  assign out_ch.fill_count       = out_res_r.fill_count;
  assign out_ch.read_data        = out_res_r.read_data;

endmodule

### test/tb.sv
// Self-checking testbench for the transmit ring buffer with DMA chunk descriptors.
`timescale 1ns / 100ps

module tb;
  import txrb_pkg::*;

  // Operation codes the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int N_DIRECTED      = 22;
  localparam int TOTAL_WORDS     = 1100;
  localparam int QUIET_WORDS     = 150;
  localparam int PRESSURE_AT     = 400;
  localparam int PRESSURE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] idx;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  txrb_in_if  in_ch ();
  txrb_out_if out_ch ();

  tx_ring_buffer_dma_chunker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the ring and its pointers.
  logic [BYTE_W-1:0] ring_copy [BUF_DEPTH];
  bit                entry_written [BUF_DEPTH];
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  int unsigned       fill_level;
  int unsigned       chunk_size;
  bit                ring_idle;

  result_t   expected_words [$];
  stim_row_t directed_rows [N_DIRECTED];

  int  words_sent;
  int  results_seen;
  int  mismatch_count;
  int  chunks_launched;
  int  full_chunks;
  int  overflows_refused;
  int  stall_cycles;
  bit  quiet_tail;
  bit  pressure_done;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random byte for data and index fields.
  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  // Launch the next chunk from the read position if anything is queued.
  function automatic void launch_chunk(inout result_t r);
    int unsigned room;
    room       = BUF_DEPTH - rd_pos;
    chunk_size = (fill_level < room) ? fill_level : room;
    if (chunk_size != 0) begin
      ring_idle           = 1'b0;
      r.transfer_started  = 1'b1;
      r.transfer_start    = INDEX_W'(rd_pos);
      r.transfer_length   = LEN_W'(chunk_size);
    end
  endfunction

  // Apply one operation word to the shadow state and return the result word it yields.
  function automatic result_t ring_predict(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] data,
                                           input logic [INDEX_W-1:0] idx);
    result_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        if (fill_level >= BUF_DEPTH) begin
          r.status = 1'b1;
        end else begin
          ring_copy[wr_pos]     = data;
          entry_written[wr_pos] = 1'b1;
          wr_pos                = (wr_pos + 1) % BUF_DEPTH;
          fill_level++;
        end
      end
      OP_START: begin
        if (ring_idle) launch_chunk(r);
      end
      OP_DONE: begin
        if (!ring_idle) begin
          fill_level = (chunk_size <= fill_level) ? fill_level - chunk_size : 0;
          if (chunk_size >= BUF_DEPTH - rd_pos) rd_pos = 0;
          else rd_pos += chunk_size;
          if (fill_level == 0) ring_idle = 1'b1;
          else launch_chunk(r);
        end
      end
      OP_STOP: begin
        ring_idle  = 1'b1;
        rd_pos     = 0;
        wr_pos     = 0;
        fill_level = 0;
        chunk_size = 0;
      end
      OP_READ: begin
        if (idx < BUF_DEPTH) r.read_data = ring_copy[idx];
      end
      default: ;
    endcase
    r.idle       = ring_idle;
    r.fill_count = LEN_W'(fill_level);
    return r;
  endfunction

  // Build a typed-in result word for the directed table.
  function automatic result_t word_of(input logic status, input logic started,
                                      input int start, input int len, input logic idle,
                                      input int fill, input logic [BYTE_W-1:0] rdata);
    result_t r;
    r.status           = status;
    r.transfer_started = started;
    r.transfer_start   = INDEX_W'(start);
    r.transfer_length  = LEN_W'(len);
    r.idle             = idle;
    r.fill_count       = LEN_W'(fill);
    r.read_data        = rdata;
    return r;
  endfunction

  function automatic stim_row_t row_of(input logic [OP_W-1:0] op,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [INDEX_W-1:0] idx,
                                       input bit typed, input result_t want);
    stim_row_t s;
    s.op    = op;
    s.data  = data;
    s.idx   = idx;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Offer one word, wait for it to be taken, then queue its expected result.
  // Called and returns at a falling edge.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                           input logic [INDEX_W-1:0] idx, input bit typed,
                           input result_t want);
    result_t predicted;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.data_byte   <= data;
    in_ch.fetch_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = ring_predict(op, data, idx);
    expected_words.push_back(typed ? want : predicted);
    words_sent++;
    if (predicted.transfer_started) chunks_launched++;
    if (predicted.transfer_length == LEN_W'(BUF_DEPTH)) full_chunks++;
    if (predicted.status) overflows_refused++;
    @(negedge clk);
  endtask

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at result %0d, %s: expected %0h, got %0h",
               results_seen, field, want_v, got_v);
  endtask

  // Result side: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status           = out_ch.status;
      got.transfer_started = out_ch.transfer_started;
      got.transfer_start   = out_ch.transfer_start;
      got.transfer_length  = out_ch.transfer_length;
      got.idle             = out_ch.idle;
      got.fill_count       = out_ch.fill_count;
      got.read_data        = out_ch.read_data;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word %0d: %p", results_seen, got);
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status)
          report_field("status", 32'(want.status), 32'(got.status));
        if (got.transfer_started !== want.transfer_started)
          report_field("transfer_started", 32'(want.transfer_started),
                       32'(got.transfer_started));
        if (got.transfer_start !== want.transfer_start)
          report_field("transfer_start", 32'(want.transfer_start), 32'(got.transfer_start));
        if (got.transfer_length !== want.transfer_length)
          report_field("transfer_length", 32'(want.transfer_length),
                       32'(got.transfer_length));
        if (got.idle !== want.idle)
          report_field("idle", 32'(want.idle), 32'(got.idle));
        if (got.fill_count !== want.fill_count)
          report_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
        if (got.read_data !== want.read_data)
          report_field("read_data", 32'(want.read_data), 32'(got.read_data));
      end
      results_seen++;
    end
  end

  // Receiver: random stall bursts, one long hold-off to back the block up,
  // and no stalls in the tail of the run.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, expected_words.size());
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: directed table, then random sequences.
  initial begin
    int                 pick;
    int                 burst;
    int                 probe;
    bit                 found;
    logic [INDEX_W-1:0] idx;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_PUT;
    in_ch.data_byte   = '0;
    in_ch.fetch_index = '0;
    wr_pos            = 0;
    rd_pos            = 0;
    fill_level        = 0;
    chunk_size        = 0;
    ring_idle         = 1'b1;
    words_sent        = 0;
    results_seen      = 0;
    mismatch_count    = 0;
    chunks_launched   = 0;
    full_chunks       = 0;
    overflows_refused = 0;
    quiet_tail        = 1'b0;
    pressure_done     = 1'b0;
    for (int k = 0; k < BUF_DEPTH; k++) begin
      ring_copy[k]     = '0;
      entry_written[k] = 1'b0;
    end

    // Start and done on an empty ring, data extremes, a first chunk, busy start,
    // chained chunk, ignored codes, stop when idle and busy.
    directed_rows[0]  = row_of(OP_START, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 0, 8'h00));
    directed_rows[1]  = row_of(OP_DONE, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 0, 8'h00));
    directed_rows[2]  = row_of(OP_PUT, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 1, 8'h00));
    directed_rows[3]  = row_of(OP_PUT, 8'hFF, 8'h00, 1, word_of(0, 0, 0, 0, 1, 2, 8'h00));
    directed_rows[4]  = row_of(OP_READ, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 2, 8'h00));
    directed_rows[5]  = row_of(OP_READ, 8'h00, 8'h01, 1, word_of(0, 0, 0, 0, 1, 2, 8'hFF));
    directed_rows[6]  = row_of(OP_START, 8'h00, 8'h00, 1, word_of(0, 1, 0, 2, 0, 2, 8'h00));
    directed_rows[7]  = row_of(OP_START, 8'h00, 8'h00, 0, '0);
    directed_rows[8]  = row_of(OP_PUT, 8'hA5, 8'h00, 0, '0);
    directed_rows[9]  = row_of(OP_DONE, 8'h00, 8'h00, 0, '0);
    directed_rows[10] = row_of(OP_READ, 8'h00, 8'h02, 0, '0);
    directed_rows[11] = row_of(OP_DONE, 8'h00, 8'h00, 0, '0);
    directed_rows[12] = row_of(OP_SPARE_LO, 8'hFF, 8'hFF, 0, '0);
    directed_rows[13] = row_of(OP_SPARE_LO + 3'd1, 8'h55, 8'hAA, 0, '0);
    directed_rows[14] = row_of(OP_SPARE_HI, 8'hAA, 8'h55, 0, '0);
    directed_rows[15] = row_of(OP_PUT, 8'h5A, 8'h00, 0, '0);
    directed_rows[16] = row_of(OP_STOP, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 0, 8'h00));
    directed_rows[17] = row_of(OP_DONE, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 0, 8'h00));
    directed_rows[18] = row_of(OP_PUT, 8'h3C, 8'h00, 0, '0);
    directed_rows[19] = row_of(OP_START, 8'h00, 8'h00, 0, '0);
    directed_rows[20] = row_of(OP_STOP, 8'h00, 8'h00, 1, word_of(0, 0, 0, 0, 1, 0, 8'h00));
    directed_rows[21] = row_of(OP_READ, 8'h00, 8'h00, 0, '0);

    // Synchronous reset, released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < N_DIRECTED; n++)
      send_word(directed_rows[n].op, directed_rows[n].data, directed_rows[n].idx,
                directed_rows[n].typed, directed_rows[n].want);

    // Random part: mostly fill and drain sequences, with noise mixed in.
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= TOTAL_WORDS - QUIET_WORDS) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // Fill the ring to the top and push a few more to hit overflow.
        if ($urandom_range(0, 1) == 1) send_word(OP_STOP, rand_byte(), rand_byte(), 0, '0);
        burst = BUF_DEPTH - fill_level + $urandom_range(1, 3);
        repeat (burst) send_word(OP_PUT, rand_byte(), rand_byte(), 0, '0);
      end else if (pick < 35) begin
        burst = $urandom_range(1, 24);
        repeat (burst) send_word(OP_PUT, rand_byte(), rand_byte(), 0, '0);
      end else if (pick < 47) begin
        send_word(OP_START, rand_byte(), rand_byte(), 0, '0);
      end else if (pick < 65) begin
        send_word(OP_DONE, rand_byte(), rand_byte(), 0, '0);
      end else if (pick < 73) begin
        // Drain the ring chunk by chunk.
        send_word(OP_START, rand_byte(), rand_byte(), 0, '0);
        while (!ring_idle) begin
          if ($urandom_range(0, 3) == 0 && fill_level != 0)
            send_word(OP_READ, rand_byte(), INDEX_W'(rd_pos), 0, '0);
          send_word(OP_DONE, rand_byte(), rand_byte(), 0, '0);
        end
      end else if (pick < 85) begin
        // Read back only entries that have been written at some point.
        probe = $urandom_range(0, BUF_DEPTH - 1);
        found = 1'b0;
        for (int k = 0; k < BUF_DEPTH && !found; k++) begin
          if (entry_written[(probe + k) % BUF_DEPTH]) begin
            idx   = INDEX_W'((probe + k) % BUF_DEPTH);
            found = 1'b1;
          end
        end
        if (found) send_word(OP_READ, rand_byte(), idx, 0, '0);
        else send_word(OP_START, rand_byte(), rand_byte(), 0, '0);
      end else if (pick < 90) begin
        send_word(OP_STOP, rand_byte(), rand_byte(), 0, '0);
      end else begin
        send_word(OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO)),
                  rand_byte(), rand_byte(), 0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    // Let the last results come out, then wait on for stray words.
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d results: %0d chunks, %0d of full ring length,",
             words_sent, results_seen, chunks_launched, full_chunks);
    $display("%0d puts refused on a full ring, %0d mismatches",
             overflows_refused, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
